[hdl/fnt_pkg.sv]
`timescale 1ns / 1ps

package fnt_pkg;

   localparam int NAME_W = 72;
   localparam int HEAD_W = 64;
   localparam int TAIL_W = 8;
   localparam int HELD_W = 5;

   typedef enum logic [1:0] {
      OP_CREATE = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_LIST   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      RS_CREATED   = 3'd0,
      RS_DELETED   = 3'd1,
      RS_FOUND     = 3'd2,
      RS_NOT_FOUND = 3'd3,
      RS_FULL      = 3'd4,
      RS_LISTED    = 3'd5,
      RS_EMPTY     = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_MOVE,
      S_LIST_RD,
      S_LIST_OUT,
      S_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       scan_step;
      logic       del_read;
      logic       move_wr;
      logic       app_wr;
      logic       list_rd;
      logic       load;
      logic       load_entry;
      status_type code;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      opcode_type op;
      logic       count_zero;
      logic       full;
      logic       hit;
      logic       idx_lt_count;
      logic       cmp_vld;
      logic       out_free;
      logic       list_last;
   } stat_type;

endpackage

[hdl/fnt_ctrl.sv]
`timescale 1ns / 1ps

module fnt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fnt_pkg::stat_type stat,
   output fnt_pkg::cmd_type  cmd
);

   fnt_pkg::state_type  state_ff, state_in;
   fnt_pkg::status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fnt_pkg::S_IDLE;
         code_ff  <= fnt_pkg::RS_CREATED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      cmd       = '0;
      cmd.code  = code_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         fnt_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = fnt_pkg::S_EXEC;
            end
         end
         fnt_pkg::S_EXEC: begin
            unique case (stat.op)
               fnt_pkg::OP_CREATE: begin
                  if (stat.full) begin
                     code_in = fnt_pkg::RS_FULL;
                  end else begin
                     cmd.app_wr = 1'b1;
                     code_in    = fnt_pkg::RS_CREATED;
                  end
                  state_in = fnt_pkg::S_RESP;
               end
               fnt_pkg::OP_DELETE, fnt_pkg::OP_SEARCH: begin
                  state_in = fnt_pkg::S_SCAN;
               end
               default: begin
                  if (stat.count_zero) begin
                     code_in  = fnt_pkg::RS_EMPTY;
                     state_in = fnt_pkg::S_RESP;
                  end else begin
                     state_in = fnt_pkg::S_LIST_RD;
                  end
               end
            endcase
         end
         fnt_pkg::S_SCAN: begin
            // Reads run one entry ahead of the compare.
            if (stat.hit) begin
               if (stat.op == fnt_pkg::OP_DELETE) begin
                  cmd.del_read = 1'b1;
                  state_in     = fnt_pkg::S_MOVE;
               end else begin
                  code_in  = fnt_pkg::RS_FOUND;
                  state_in = fnt_pkg::S_RESP;
               end
            end else if (!stat.cmp_vld && !stat.idx_lt_count) begin
               code_in  = fnt_pkg::RS_NOT_FOUND;
               state_in = fnt_pkg::S_RESP;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         fnt_pkg::S_MOVE: begin
            cmd.move_wr = 1'b1;
            code_in     = fnt_pkg::RS_DELETED;
            state_in    = fnt_pkg::S_RESP;
         end
         fnt_pkg::S_LIST_RD: begin
            cmd.list_rd = 1'b1;
            state_in    = fnt_pkg::S_LIST_OUT;
         end
         fnt_pkg::S_LIST_OUT: begin
            if (stat.out_free) begin
               cmd.load       = 1'b1;
               cmd.load_entry = 1'b1;
               cmd.code       = fnt_pkg::RS_LISTED;
               state_in       = stat.list_last ? fnt_pkg::S_IDLE : fnt_pkg::S_LIST_RD;
            end
         end
         fnt_pkg::S_RESP: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = fnt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fnt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[hdl/fnt_datapath.sv]
`timescale 1ns / 1ps

module fnt_datapath #(
   parameter int MAX_FILES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 req_opcode,
   input  logic [fnt_pkg::HEAD_W-1:0] req_name_head,
   input  logic [fnt_pkg::TAIL_W-1:0] req_name_tail,
   input  fnt_pkg::cmd_type           cmd,
   output fnt_pkg::stat_type          stat,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic [fnt_pkg::HEAD_W-1:0] rsp_out_head,
   output logic [fnt_pkg::TAIL_W-1:0] rsp_out_tail,
   output logic [fnt_pkg::HELD_W-1:0] rsp_entries_held,
   output logic                       rsp_last
);

   localparam int AW = $clog2(MAX_FILES);
   localparam int CW = $clog2(MAX_FILES + 1);
   localparam int HELD_W = fnt_pkg::HELD_W;

   // A name ends at its first zero character; everything after it reads as zero.
   function automatic logic [fnt_pkg::NAME_W-1:0] canon_name(
      input logic [fnt_pkg::HEAD_W-1:0] head,
      input logic [fnt_pkg::TAIL_W-1:0] tail
   );
      logic [fnt_pkg::HEAD_W-1:0] out;
      logic                       ended;
      out   = '0;
      ended = 1'b0;
      for (int b = 0; b < 8; b++) begin
         if (head[8*b +: 8] == 8'd0) ended = 1'b1;
         if (!ended) out[8*b +: 8] = head[8*b +: 8];
      end
      canon_name = {(ended ? 8'd0 : tail), out};
   endfunction

   logic [fnt_pkg::NAME_W-1:0] mem [MAX_FILES];
   logic [fnt_pkg::NAME_W-1:0] rd_data_ff;
   logic [fnt_pkg::NAME_W-1:0] name_ff;
   fnt_pkg::opcode_type        op_ff;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic                       cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]              cmp_idx_ff;
   logic [AW-1:0]              del_idx_ff;
   logic                       rsp_vld_ff, rsp_vld_in;
   fnt_pkg::status_type        status_ff;
   logic [fnt_pkg::NAME_W-1:0] out_name_ff;
   logic [fnt_pkg::HELD_W-1:0] held_ff;
   logic                       last_ff;

   logic          idx_lt_count;
   logic [CW-1:0] count_m1;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          out_free;

   assign idx_lt_count = idx_ff < count_ff;
   assign count_m1     = count_ff - CW'(1);
   assign rd_en        = (cmd.scan_step && idx_lt_count) || cmd.list_rd || cmd.del_read;
   assign rd_addr      = cmd.del_read ? count_m1[AW-1:0] : idx_ff[AW-1:0];
   assign out_free     = !rsp_vld_ff || !rsp_stall;

   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      cmp_vld_in = cmp_vld_ff;
      rsp_vld_in = rsp_vld_ff;
      if (cmd.app_wr) count_in = count_ff + CW'(1);
      if (cmd.move_wr) count_in = count_m1;
      if (cmd.capture) begin
         idx_in     = '0;
         cmp_vld_in = 1'b0;
      end
      if (cmd.scan_step) begin
         cmp_vld_in = idx_lt_count;
         if (idx_lt_count) idx_in = idx_ff + CW'(1);
      end
      if (cmd.list_rd) idx_in = idx_ff + CW'(1);
      if (cmd.load) rsp_vld_in = 1'b1;
      else if (!rsp_stall) rsp_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         name_ff <= canon_name(req_name_head, req_name_tail);
         op_ff   <= fnt_pkg::opcode_type'(req_opcode);
      end
      if (cmd.scan_step) cmp_idx_ff <= idx_ff[AW-1:0];
      if (cmd.del_read) del_idx_ff <= cmp_idx_ff;
      if (rd_en) rd_data_ff <= mem[rd_addr];
      if (cmd.load) begin
         status_ff   <= cmd.code;
         out_name_ff <= cmd.load_entry ? rd_data_ff : '0;
         held_ff     <= HELD_W'(count_ff);
         last_ff     <= cmd.load_entry ? (idx_ff == count_ff) : 1'b1;
      end
   end

   // One write port: append at the count, or move the last entry into a freed slot.
   always_ff @(posedge clock) begin
      if (cmd.app_wr) begin
         mem[count_ff[AW-1:0]] <= name_ff;
      end else if (cmd.move_wr) begin
         mem[del_idx_ff] <= rd_data_ff;
      end
   end

   always_comb begin
      stat.op           = op_ff;
      stat.count_zero   = count_ff == '0;
      stat.full         = count_ff >= CW'(MAX_FILES);
      stat.hit          = cmp_vld_ff && (rd_data_ff == name_ff);
      stat.idx_lt_count = idx_lt_count;
      stat.cmp_vld      = cmp_vld_ff;
      stat.out_free     = out_free;
      stat.list_last    = idx_ff == count_ff;
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_head     = out_name_ff[fnt_pkg::HEAD_W-1:0];
   assign rsp_out_tail     = out_name_ff[fnt_pkg::NAME_W-1:fnt_pkg::HEAD_W];
   assign rsp_entries_held = held_ff;
   assign rsp_last         = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_FILES))
      else $error("entry count exceeds table size");

   a_no_append_full: assert property (@(posedge clock) disable iff (reset)
      cmd.app_wr |-> count_ff < CW'(MAX_FILES))
      else $error("append on a full table");

   a_delete_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.move_wr |=> count_ff == $past(count_m1))
      else $error("delete did not decrement the count");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> out_free)
      else $error("result loaded over an untaken result");

endmodule

[hdl/flat_name_table_core.sv]
`timescale 1ns / 1ps
// Create appends through the execute and respond states; search and delete compare one
// entry per cycle, and delete then moves the last entry into the freed slot.
// List alternates reads on the single table read port with loads of each result.
// One operation is in work at a time; a finished result waits in the output register.
// Reset clears the entry count and control state; stored names are not cleared.
module flat_name_table_core #(
   parameter int MAX_FILES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_name_head,
   input  logic [7:0]  req_name_tail,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_out_head,
   output logic [7:0]  rsp_out_tail,
   output logic [4:0]  rsp_entries_held,
   output logic        rsp_last
);

   fnt_pkg::cmd_type  cmd;
   fnt_pkg::stat_type stat;

   fnt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fnt_datapath #(
      .MAX_FILES (MAX_FILES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_opcode),
      .req_name_head    (req_name_head),
      .req_name_tail    (req_name_tail),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_head     (rsp_out_head),
      .rsp_out_tail     (rsp_out_tail),
      .rsp_entries_held (rsp_entries_held),
      .rsp_last         (rsp_last)
   );

endmodule

[dv/flat_name_table_core_tb.sv]
`timescale 1ns / 1ps

module flat_name_table_core_tb;

   localparam int TABLE_DEPTH = 16;
   localparam int POOL_SIZE = 12;
   localparam int RANDOM_ITEMS = 200;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 60;
   localparam int LONG_HOLD = 400;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } op_mix_type;

   typedef struct {
      fnt_pkg::status_type status;
      logic [63:0]         head;
      logic [7:0]          tail;
      logic [4:0]          held;
      logic                last;
   } dir_result_type;

   function automatic logic [71:0] visible_name(logic [63:0] head, logic [7:0] tail);
      logic [63:0] kept;
      logic        ended;
      kept = '0;
      ended = 1'b0;
      for (int b = 0; b < 8; b++) begin
         if (head[8*b +: 8] == 8'd0) ended = 1'b1;
         if (!ended) kept[8*b +: 8] = head[8*b +: 8];
      end
      return {ended ? 8'd0 : tail, kept};
   endfunction

   class directory_tracker;
      logic [71:0] names [TABLE_DEPTH];
      int unsigned held;
      dir_result_type expected_results [$];
      int unsigned errors;

      function new();
         held = 0;
         errors = 0;
      endfunction

      function void push_result(fnt_pkg::status_type st, logic [71:0] name, logic last);
         dir_result_type r;
         r.status = st;
         r.head = name[63:0];
         r.tail = name[71:64];
         r.held = held[4:0];
         r.last = last;
         expected_results.push_back(r);
      endfunction

      function int find_first(logic [71:0] name);
         for (int i = 0; i < held; i++)
            if (names[i] == name) return i;
         return -1;
      endfunction

      function void note_request(fnt_pkg::opcode_type op, logic [63:0] head,
                                 logic [7:0] tail);
         logic [71:0] name;
         int          idx;
         name = visible_name(head, tail);
         case (op)
            fnt_pkg::OP_CREATE: begin
               if (held >= TABLE_DEPTH) begin
                  push_result(fnt_pkg::RS_FULL, '0, 1'b1);
               end else begin
                  names[held] = name;
                  held++;
                  push_result(fnt_pkg::RS_CREATED, '0, 1'b1);
               end
            end
            fnt_pkg::OP_DELETE: begin
               idx = find_first(name);
               if (idx < 0) begin
                  push_result(fnt_pkg::RS_NOT_FOUND, '0, 1'b1);
               end else begin
                  // The last entry fills the hole, which may be its own slot.
                  names[idx] = names[held - 1];
                  held--;
                  push_result(fnt_pkg::RS_DELETED, '0, 1'b1);
               end
            end
            fnt_pkg::OP_SEARCH: begin
               idx = find_first(name);
               push_result(idx < 0 ? fnt_pkg::RS_NOT_FOUND : fnt_pkg::RS_FOUND, '0, 1'b1);
            end
            default: begin
               if (held == 0) push_result(fnt_pkg::RS_EMPTY, '0, 1'b1);
               for (int i = 0; i < held; i++)
                  push_result(fnt_pkg::RS_LISTED, names[i], i + 1 == held);
            end
         endcase
      endfunction

      function void check_response(logic [2:0] status, logic [63:0] head, logic [7:0] tail,
                                   logic [4:0] entries, logic last);
         dir_result_type e;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result status %0d head %h tail %h held %0d last %0b",
                     $time, status, head, tail, entries, last);
            errors++;
            return;
         end
         e = expected_results.pop_front();
         if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            errors++;
         end
         if (head !== e.head) begin
            $display("%0t: out_head expected %h actual %h", $time, e.head, head);
            errors++;
         end
         if (tail !== e.tail) begin
            $display("%0t: out_tail expected %h actual %h", $time, e.tail, tail);
            errors++;
         end
         if (entries !== e.held) begin
            $display("%0t: entries_held expected %0d actual %0d", $time, e.held, entries);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [63:0] req_name_head = '0;
   logic [7:0]  req_name_tail = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_out_head;
   logic [7:0]  rsp_out_tail;
   logic [4:0]  rsp_entries_held;
   logic        rsp_last;

   directory_tracker tracker = new();

   logic [63:0] pool_head [POOL_SIZE];
   logic [7:0]  pool_tail [POOL_SIZE];
   int          pool_len [POOL_SIZE];

   int sender_mode = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int stall_left = 0;
   int receiver_mode = 0;
   int receiver_cycles = 0;
   int idle_cycles = 0;

   flat_name_table_core #(
      .MAX_FILES(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_name_head(req_name_head),
      .req_name_tail(req_name_tail),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_head(rsp_out_head),
      .rsp_out_tail(rsp_out_tail),
      .rsp_entries_held(rsp_entries_held),
      .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap(int mode);
      int r;
      if (mode == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one item and returns once it has been taken.
   task automatic send_request(fnt_pkg::opcode_type op, logic [63:0] head, logic [7:0] tail);
      int gap;
      gap = pick_gap(sender_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_name_head <= head;
      req_name_tail <= tail;
      do @(posedge clock); while (req_stall);
      tracker.note_request(op, head, tail);
   endtask

   // A name of length len: nonzero characters, then a zero terminator unless all nine are used.
   task automatic build_pool_name(int k, int len);
      logic [63:0] head;
      head = '0;
      for (int b = 0; b < 8; b++)
         if (b < len) head[8*b +: 8] = 8'($urandom_range(1, 255));
      pool_head[k] = head;
      pool_tail[k] = (len == 9) ? 8'($urandom_range(1, 255)) : 8'd0;
      pool_len[k] = len;
   endtask

   // Presents a pool name with random junk after its terminator.
   task automatic dress_name(int k, output logic [63:0] head, output logic [7:0] tail);
      head = pool_head[k];
      tail = pool_tail[k];
      for (int b = 0; b < 8; b++)
         if (b > pool_len[k] && $urandom_range(0, 1))
            head[8*b +: 8] = 8'($urandom_range(0, 255));
      if (pool_len[k] < 8 && $urandom_range(0, 1)) tail = 8'($urandom_range(0, 255));
   endtask

   task automatic send_pool_name(fnt_pkg::opcode_type op, int k);
      logic [63:0] head;
      logic [7:0]  tail;
      dress_name(k, head, tail);
      send_request(op, head, tail);
   endtask

   function automatic fnt_pkg::opcode_type pick_op(op_mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (r < 60) return fnt_pkg::OP_CREATE;
            if (r < 75) return fnt_pkg::OP_SEARCH;
            if (r < 90) return fnt_pkg::OP_DELETE;
            return fnt_pkg::OP_LIST;
         end
         MIX_DRAIN: begin
            if (r < 15) return fnt_pkg::OP_CREATE;
            if (r < 35) return fnt_pkg::OP_SEARCH;
            if (r < 90) return fnt_pkg::OP_DELETE;
            return fnt_pkg::OP_LIST;
         end
         default: begin
            if (r < 35) return fnt_pkg::OP_CREATE;
            if (r < 60) return fnt_pkg::OP_SEARCH;
            if (r < 88) return fnt_pkg::OP_DELETE;
            return fnt_pkg::OP_LIST;
         end
      endcase
   endfunction

   initial begin
      op_mix_type          mix;
      fnt_pkg::opcode_type op;
      logic [63:0]         head;
      logic [7:0]          tail;

      for (int k = 0; k < POOL_SIZE; k++) build_pool_name(k, k % 10);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, name extremes, duplicates, delete paths, full table.
      send_request(fnt_pkg::OP_LIST, '0, '0);
      send_request(fnt_pkg::OP_DELETE, 64'h41, 8'h00);
      send_request(fnt_pkg::OP_CREATE, '1, 8'hFF);
      send_request(fnt_pkg::OP_CREATE, '0, 8'h5A);
      send_request(fnt_pkg::OP_CREATE, 64'hA5C3_9E11_7700_0041, 8'h3C);
      send_request(fnt_pkg::OP_CREATE, 64'h41, 8'h00);
      send_request(fnt_pkg::OP_SEARCH, 64'hFFFF_FFFF_FFFF_0041, 8'hFF);
      send_request(fnt_pkg::OP_LIST, '0, '0);
      // The first match is not the last entry, so the last one moves into its slot.
      send_request(fnt_pkg::OP_DELETE, 64'h41, 8'h00);
      // Now the remaining copy sits in the final position.
      send_request(fnt_pkg::OP_DELETE, 64'h0000_0000_0000_0041, 8'h77);
      send_request(fnt_pkg::OP_DELETE, 64'h41, 8'h00);
      for (int k = 0; k < TABLE_DEPTH - 2; k++)
         send_pool_name(fnt_pkg::OP_CREATE, k % POOL_SIZE);
      send_request(fnt_pkg::OP_CREATE, 64'h0123_4567_89AB_CDEF, 8'h10);
      send_request(fnt_pkg::OP_LIST, '0, '0);
      send_request(fnt_pkg::OP_DELETE, '1, 8'hFF);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) begin
            mix = op_mix_type'($urandom_range(0, 2));
            sender_mode = $urandom_range(0, 3);
         end
         if (i == 110) hold_requests <= hold_requests + 1;
         op = pick_op(mix);
         if ($urandom_range(0, 99) < 80) begin
            dress_name($urandom_range(0, POOL_SIZE - 1), head, tail);
         end else begin
            head = {$urandom, $urandom};
            tail = 8'($urandom_range(0, 255));
         end
         send_request(op, head, tail);
      end
      req_valid <= 1'b0;

      while (tracker.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.expected_results.size() == 0)
         $display("flat_name_table_core: match");
      else
         $display("flat_name_table_core: mismatch");
      $finish;
   end

   // Result side: checks each transfer and chooses the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            tracker.check_response(rsp_status, rsp_out_head, rsp_out_tail, rsp_entries_held,
                                   rsp_last);
         receiver_cycles++;
         if (receiver_cycles % 150 == 0) receiver_mode = $urandom_range(0, 3);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (receiver_mode == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            case ($urandom_range(0, 99)) inside
               [0:59]: rsp_stall <= 1'b0;
               [60:91]: begin
                  rsp_stall <= 1'b1;
                  stall_left = $urandom_range(0, 3);
               end
               default: begin
                  rsp_stall <= 1'b1;
                  stall_left = $urandom_range(10, 60);
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("flat_name_table_core: mismatch");
            $finish;
         end
      end
   end

endmodule
